// File: hw/rtl/stbs_pkg.sv
// shared types, constants and helpers for the sorted table binary search block
`default_nettype none

package stbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths of the transfers
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 11;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // input transfer
    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] value;
    } stbs_req_t;

    // result transfer
    typedef struct packed {
        logic               found;
        logic               status;
        logic [ENTRY_W-1:0] entry_count;
    } stbs_rsp_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } stbs_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic do_load;
        logic do_clear;
        logic search_init;
        logic issue_read;
        logic step_right;
        logic step_left;
        logic finish;
        logic found;
        logic reject;
    } stbs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                full;
        logic                range_open;
        logic                key_eq;
        logic                key_lt;
    } stbs_sts_t;

    // sign extend the 32-bit field, then keep the table word width
    function automatic word_t to_word(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[WORD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sorted_table_binary_search.sv
// top level of the sorted table binary search block
//
// Commands enter on request (opcode, value) at a clock edge where start is
// high and busy is low. Load appends value to the table, search looks the
// key up by binary search over the words loaded so far, clear empties the
// table. Loads must arrive in ascending signed order for search to be exact.
// Every command gives one result on result, marked by done for exactly one
// cycle; the receiver cannot stall it and must take it in that cycle.
// Load, clear and the unused opcode give their result one cycle after the
// transfer and keep busy low, so a command can be sent every cycle.
// Search holds busy high while it runs, alternating an interval check with
// a registered memory read of the probe word, until the key is found or
// the interval is empty. The single registered read port of the table
// memory sets the probe rate. A full table rejects a load with status
// set. Reset empties the table (count to zero) at once; no clearing pass
// is needed.
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire stbs_req_t request,
    output logic           busy,
    output logic           done,
    output stbs_rsp_t      result
);

    stbs_cmd_t cmd;
    stbs_sts_t sts;

    // controller
    stbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath
    stbs_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

`ifndef SYNTHESIS
    // every accepted command either reports next cycle or keeps searching
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transfer neither reported nor searching");

    // a rejected load never reports found
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.found && result.status))
        else $error("found and status set together");

    // a rejected load only happens on a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.entry_count == ENTRY_W'(TABLE_DEPTH)))
        else $error("load rejected on a table that is not full");

    // a probe read is only issued with a non-empty interval
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> (sts.range_open && busy))
        else $error("probe issued on empty interval");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/stbs_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stbs_ctrl.sv
// controller state machine for the sorted table binary search block
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire stbs_sts_t sts,
    output logic           busy,
    output stbs_cmd_t      cmd
);

    stbs_state_t state_reg;
    stbs_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (sts.opcode == OP_SEARCH))
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (sts.range_open)
                begin
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMPARE:
            begin
                if (sts.key_eq)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    unique case (sts.opcode)
                        OP_LOAD:
                        begin
                            cmd.do_load = 1'b1;
                            cmd.reject  = sts.full;
                            cmd.finish  = 1'b1;
                        end
                        OP_SEARCH:
                        begin
                            cmd.search_init = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.do_clear = 1'b1;
                            cmd.finish   = 1'b1;
                        end
                        default:
                        begin
                            // unused opcode: report current count only
                            cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                // empty interval ends the search as not found
                if (sts.range_open)
                begin
                    cmd.issue_read = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                end
            end
            ST_COMPARE:
            begin
                if (sts.key_eq)
                begin
                    cmd.finish = 1'b1;
                    cmd.found  = 1'b1;
                end
                else if (sts.key_lt)
                begin
                    cmd.step_right = 1'b1;
                end
                else
                begin
                    cmd.step_left = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/stbs_dp.sv
// datapath: table memory, count, search bounds and result register
`default_nettype none

module stbs_dp
    import stbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stbs_req_t request,
    input  wire stbs_cmd_t cmd,
    output stbs_sts_t      sts,
    output stbs_rsp_t      result,
    output logic           done
);

    cnt_t      count_reg;
    cnt_t      count_next;
    cnt_t      lo_reg;
    cnt_t      lo_next;
    cnt_t      hi_reg;
    cnt_t      hi_next;
    cnt_t      mid_reg;
    cnt_t      mid_next;
    word_t     key_reg;
    word_t     key_next;
    stbs_rsp_t result_reg;
    stbs_rsp_t result_next;
    logic      done_reg;
    logic      done_next;

    word_t     rd_data;
    logic      full;
    logic      wr_en;

    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en = cmd.do_load && !full;

    // table memory
    stbs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (to_word(request.value)),
        .rd_en   (cmd.issue_read),
        .rd_addr (mid_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // search interval and probe position
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
        if (cmd.search_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        else if (cmd.step_right)
        begin
            lo_next = mid_reg + 1'b1;
        end
        else if (cmd.step_left)
        begin
            hi_next = mid_reg;
        end
    end

    // key capture
    assign key_next = cmd.accept ? to_word(request.value) : key_reg;

    // result transfer
    always_comb
    begin
        result_next = result_reg;
        done_next   = cmd.finish;
        if (cmd.finish)
        begin
            result_next.found       = cmd.found;
            result_next.status      = cmd.reject;
            result_next.entry_count = ENTRY_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        key_reg    <= key_next;
        result_reg <= result_next;
        if (cmd.issue_read)
        begin
            mid_reg <= mid_next;
        end
    end

    // status to controller
    always_comb
    begin
        sts.opcode     = request.opcode;
        sts.full       = full;
        sts.range_open = (lo_reg < hi_reg);
        sts.key_eq     = (rd_data == key_reg);
        sts.key_lt     = ($signed(rd_data) < $signed(key_reg));
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire
